FILE: design/link_etx_estimator_table_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the link ETX estimator table unit
// ---------------------------------------------------------------------------
`ifndef LINK_ETX_ESTIMATOR_TABLE_UNIT_ASSERT_SVH
`define LINK_ETX_ESTIMATOR_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define LETX_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LETX_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/letx_pkg.sv
// ---------------------------------------------------------------------------
// letx_pkg
// Shared types, codes and constants of the link ETX estimator table unit.
// ---------------------------------------------------------------------------
`default_nettype none

package letx_pkg;

  // default sizing
  localparam int LETX_NEIGHBORS    = 16;
  localparam int LETX_COST_DIVISOR = 128;

  // field widths
  localparam int NB_W    = 4;
  localparam int ST_W    = 3;
  localparam int CNT_W   = 8;
  localparam int COST_W  = 16;
  localparam int WGT_W   = 13;
  localparam int RATIO_W = 4;

  // moving average: (90*old + 10*new) / 100 == (9*old + new) / 10
  localparam int EWMA_SCALE    = 100;
  localparam int EWMA_OLD      = 90;
  localparam int EWMA_NEW      = 10;
  localparam int OLD_K         = EWMA_OLD / EWMA_NEW;
  localparam int DIV_K         = EWMA_SCALE / EWMA_NEW;
  localparam int PENALTY_TRIES = 10;

  // reciprocal scale shared by both constant dividers
  localparam int RECIP_SH = 24;

  // op codes
  localparam logic OP_TX  = 1'b0;
  localparam logic OP_DAO = 1'b1;

  // status codes
  localparam logic [ST_W-1:0] TX_OK       = 3'd0;
  localparam logic [ST_W-1:0] TX_NOACK    = 3'd2;
  localparam logic [ST_W-1:0] DAO_UNABLE  = 3'd2;
  localparam logic [ST_W-1:0] DAO_TIMEOUT = 3'd3;

  // configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_RATIO  = 1'd1;
  localparam logic                 WEIGHT_MODE_RST = 1'b1;
  localparam logic [RATIO_W-1:0]   LONG_RATIO_RST  = 4'd2;

  typedef struct packed {
    logic             op;
    logic [NB_W-1:0]  neighbor;
    logic [ST_W-1:0]  status_code;
    logic [CNT_W-1:0] tx_count;
    logic             is_long_range;
  } in_item_t;

  typedef struct packed {
    logic              updated;
    logic [COST_W-1:0] link_cost;
    logic [WGT_W-1:0]  route_weight;
  } out_item_t;

  // controller to datapath step strobes
  typedef struct packed {
    logic cap;    // capture request, issue table read
    logic mix;    // form sample and 9*old + sample
    logic div;    // reciprocal multiply for /10
    logic upd;    // correct quotient, write table
    logic wdiv;   // reciprocal multiply for /divisor
    logic wfix;   // correct quotient, select base weight
    logic load;   // apply ratio, load result register
  } ctl_cmd_t;

endpackage

`default_nettype wire

FILE: design/letx_ctrl.sv
// ---------------------------------------------------------------------------
// letx_ctrl
// Sequencer: walks one request through the datapath steps and runs the
// input and result handshakes.
// ---------------------------------------------------------------------------
`default_nettype none
`include "link_etx_estimator_table_unit_assert.svh"

module letx_ctrl
  import letx_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output ctl_cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MIX  = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_UPD  = 7'b0001000,
    ST_WDIV = 7'b0010000,
    ST_WFIX = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_o         = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_o.cap = 1'b1;
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        cmd_o.mix = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_nxt = ST_WDIV;
      end
      ST_WDIV: begin
        cmd_o.wdiv = 1'b1;
        state_nxt  = ST_WFIX;
      end
      ST_WFIX: begin
        cmd_o.wfix = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.load    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LETX_ASSERT_NOW(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd_o), "more than one step strobe")
  `LETX_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd_o.load, out_free, "result overwritten")
  `LETX_ASSERT_NOW(a_mix_after_cap, clk, rst_n, state_r == ST_MIX,
                   $past(in_valid && in_ready), "step sequence entered without request")

endmodule

`default_nettype wire

FILE: design/letx_datapath.sv
// ---------------------------------------------------------------------------
// letx_datapath
// Cost table, valid bits, configuration registers and the arithmetic steps.
// ---------------------------------------------------------------------------
`default_nettype none

module letx_datapath
  import letx_pkg::*;
#(
  parameter int NEIGHBORS    = LETX_NEIGHBORS,
  parameter int COST_DIVISOR = LETX_COST_DIVISOR
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctl_cmd_t              cmd_i,
  input  wire in_item_t              in_data,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(NEIGHBORS);
  localparam int EXT_W = (IDX_W > NB_W) ? IDX_W : NB_W;
  localparam int X_W   = 20;                 // 9*65535 + 65535 < 2^20
  localparam int P_W   = 41;
  localparam int QD_W  = 25;
  localparam int W_W   = COST_W + RATIO_W;
  localparam logic [P_W-1:0]    M10  = P_W'((64'd1 << RECIP_SH) / DIV_K);
  localparam logic [P_W-1:0]    MDIV = P_W'((64'd1 << RECIP_SH) / COST_DIVISOR);
  localparam logic [16:0]       CDIV17 = 17'(COST_DIVISOR);
  localparam logic [QD_W-1:0]   CDIV25 = QD_W'(COST_DIVISOR);
  localparam logic [COST_W-1:0] NOACK_SAMPLE = COST_W'(PENALTY_TRIES * COST_DIVISOR);

  // configuration
  logic               mode_r;
  logic [RATIO_W-1:0] ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= WEIGHT_MODE_RST;
      ratio_r <= LONG_RATIO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WEIGHT_MODE: mode_r  <= cfg_wdata[0];
        CFG_LONG_RATIO:  ratio_r <= cfg_wdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // capture
  logic [EXT_W-1:0]  nb_ext;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  addr_r;
  logic              in_range_r;
  logic              op_r;
  logic [ST_W-1:0]   status_r;
  logic [CNT_W-1:0]  count_r;
  logic              long_r;
  logic [COST_W-1:0] rdata_r;
  logic [COST_W-1:0] mem [NEIGHBORS];
  logic [NEIGHBORS-1:0] vld_r;

  assign nb_ext  = EXT_W'(in_data.neighbor);
  assign rd_addr = nb_ext[IDX_W-1:0];

  // step registers
  logic              acc_r, was_valid_r;
  logic [COST_W-1:0] old_r, sample_r, cost_r, base_r;
  logic [X_W-1:0]    x_r;
  logic [P_W-1:0]    prod_r, wprod_r;
  out_item_t         out_r;

  // mix step
  logic              hit, acc_nxt, noack;
  logic [COST_W-1:0] old_nxt, sample_nxt;
  logic [16:0]       cnt_mul;
  logic [X_W-1:0]    x_nxt;

  always_comb begin
    hit     = in_range_r && vld_r[addr_r];
    old_nxt = hit ? rdata_r : '0;
    noack   = 1'b0;
    acc_nxt = 1'b0;
    priority if (!in_range_r) begin
      acc_nxt = 1'b0;
    end else if (op_r == OP_TX) begin
      acc_nxt = (count_r != '0) && (status_r == TX_OK || status_r == TX_NOACK);
      noack   = (status_r == TX_NOACK);
    end else begin
      acc_nxt = (status_r == DAO_UNABLE || status_r == DAO_TIMEOUT);
    end
    if (op_r == OP_DAO) begin
      cnt_mul = 17'(PENALTY_TRIES) * CDIV17;
    end else begin
      cnt_mul = 17'(count_r) * CDIV17;
    end
    sample_nxt = noack ? NOACK_SAMPLE : cnt_mul[COST_W-1:0];
    x_nxt      = X_W'(old_nxt) * X_W'(OLD_K) + X_W'(sample_nxt);
  end

  // update step: quotient of x/10, off by at most one low
  logic [COST_W-1:0] q10, q10_fix, cost_nxt;
  logic [X_W-1:0]    r10;

  always_comb begin
    q10      = prod_r[RECIP_SH +: COST_W];
    r10      = x_r - X_W'(q10) * X_W'(DIV_K);
    q10_fix  = (r10 >= X_W'(DIV_K)) ? q10 + 1'b1 : q10;
    cost_nxt = !acc_r ? old_r : (was_valid_r ? q10_fix : sample_r);
  end

  // weight step: quotient of cost/divisor, off by at most one low
  logic [COST_W-1:0] qd, qd_fix, base_nxt;
  logic [QD_W-1:0]   rem_d;

  always_comb begin
    qd       = wprod_r[RECIP_SH +: COST_W];
    rem_d    = QD_W'(cost_r) - QD_W'(qd) * CDIV25;
    qd_fix   = (rem_d >= CDIV25) ? qd + 1'b1 : qd;
    base_nxt = (mode_r && cost_r != '0) ? qd_fix : COST_W'(1);
  end

  // result
  logic [W_W-1:0] w_full;
  out_item_t      out_nxt;

  always_comb begin
    w_full = long_r ? W_W'(base_r) * W_W'(ratio_r) : W_W'(base_r);
    out_nxt.updated      = acc_r;
    out_nxt.link_cost    = in_range_r ? cost_r : '0;
    out_nxt.route_weight = acc_r ? w_full[WGT_W-1:0] : '0;
  end

  // table memory: registered read at capture, write at update
  always_ff @(posedge clk) begin
    if (cmd_i.cap) begin
      rdata_r <= mem[rd_addr];
    end
    if (cmd_i.upd && acc_r) begin
      mem[addr_r] <= cost_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd_i.upd && acc_r) begin
      vld_r[addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.cap) begin
      addr_r     <= rd_addr;
      in_range_r <= (32'(in_data.neighbor) < 32'(NEIGHBORS));
      op_r       <= in_data.op;
      status_r   <= in_data.status_code;
      count_r    <= in_data.tx_count;
      long_r     <= in_data.is_long_range;
    end
    if (cmd_i.mix) begin
      acc_r       <= acc_nxt;
      was_valid_r <= hit;
      old_r       <= old_nxt;
      sample_r    <= sample_nxt;
      x_r         <= x_nxt;
    end
    if (cmd_i.div) begin
      prod_r <= P_W'(x_r) * M10;
    end
    if (cmd_i.upd) begin
      cost_r <= cost_nxt;
    end
    if (cmd_i.wdiv) begin
      wprod_r <= P_W'(cost_r) * MDIV;
    end
    if (cmd_i.wfix) begin
      base_r <= base_nxt;
    end
    if (cmd_i.load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

FILE: design/link_etx_estimator_table_unit.sv
// Link ETX estimator table unit.
// Input channel (in_valid/in_ready/in_data) takes one transmit or DAO-ack
// report per request; result channel (out_valid/out_ready/out_data) returns
// exactly one result per request: updated flag, entry cost, parent weight.
// Config port (cfg_we/cfg_index/cfg_wdata) writes weight_mode (index 0) and
// the long-range ratio (index 1); write only while no request is in flight.
// Timing: a request runs through a seven-state sequencer (idle, mix, /10
// multiply, table write, /divisor multiply, weight select, output), one
// request at a time; the result register is loaded in the output state.
// The step order is set by the read-modify-write of the cost table through two
// reciprocal-multiply divider steps, one multiplier per step.
// in_ready is high only while the sequencer is idle; the result register
// lets a new request start while the previous result waits.
// When out_ready stays low the sequencer parks in its output state holding
// the finished result, and takes no new request.
// Reset (rst_n low, synchronous) clears all valid bits, empties the result
// register and restores weight_mode=1, long-range ratio=2; no sweep.
// ---------------------------------------------------------------------------
// link_etx_estimator_table_unit
// Top level: per-neighbor ETX cost table with parent weight output.
// ---------------------------------------------------------------------------
`default_nettype none

module link_etx_estimator_table_unit
  import letx_pkg::*;
#(
  parameter int NEIGHBORS    = LETX_NEIGHBORS,
  parameter int COST_DIVISOR = LETX_COST_DIVISOR
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // report requests
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  // results
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctl_cmd_t cmd;

  // sequencer
  letx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd_o     (cmd)
  );

  // table and arithmetic
  letx_datapath #(
    .NEIGHBORS    (NEIGHBORS),
    .COST_DIVISOR (COST_DIVISOR)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

`default_nettype wire

FILE: test/link_etx_estimator_table_unit_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// link_etx_estimator_table_unit_checker
// Watches the request, result and config ports, predicts each result and
// compares it field by field with what the unit returns.
// ---------------------------------------------------------------------------

module link_etx_estimator_table_unit_checker
  import letx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  // shadow copy of the cost table and registers
  logic [COST_W-1:0]  link_cost_tab [LETX_NEIGHBORS];
  bit                 link_seen     [LETX_NEIGHBORS];
  logic               wt_mode;
  logic [RATIO_W-1:0] wt_ratio;

  out_item_t report_results_q [$];
  int        errs;
  int        nchk;

  initial begin
    errs = 0;
    nchk = 0;
  end

  // one report in, one result out; updates the shadow table
  function automatic out_item_t estimate_link(input in_item_t r);
    out_item_t   res;
    logic [31:0] sample;
    logic [31:0] cost;
    logic [31:0] w;
    logic [7:0]  tries;
    bit          take;
    bit          noack;
    int          nb;
    res   = '0;
    take  = 1'b0;
    noack = 1'b0;
    tries = r.tx_count;
    nb    = int'(r.neighbor);
    if (nb >= LETX_NEIGHBORS) return res;
    if (r.op == OP_TX) begin
      take  = (tries != 0) && (r.status_code == TX_OK || r.status_code == TX_NOACK);
      noack = (r.status_code == TX_NOACK);
    end else if (r.status_code == DAO_UNABLE || r.status_code == DAO_TIMEOUT) begin
      take  = 1'b1;
      tries = 8'(PENALTY_TRIES);
    end
    if (take) begin
      sample = noack ? 32'(PENALTY_TRIES * LETX_COST_DIVISOR)
                     : 32'(tries) * 32'(LETX_COST_DIVISOR);
      sample &= 32'hFFFF;
      if (link_seen[nb])
        cost = (32'(link_cost_tab[nb]) * 32'(EWMA_OLD) + sample * 32'(EWMA_NEW))
               / 32'(EWMA_SCALE);
      else
        cost = sample;
      cost &= 32'hFFFF;
      link_cost_tab[nb] = cost[COST_W-1:0];
      link_seen[nb]     = 1'b1;
      if (wt_mode && cost != 0) w = cost / 32'(LETX_COST_DIVISOR);
      else w = 32'd1;
      if (r.is_long_range) w = w * 32'(wt_ratio);
      res.updated      = 1'b1;
      res.route_weight = w[WGT_W-1:0];
    end
    res.link_cost = link_cost_tab[nb];
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < LETX_NEIGHBORS; i++) begin
        link_cost_tab[i] = '0;
        link_seen[i]     = 1'b0;
      end
      wt_mode  = WEIGHT_MODE_RST;
      wt_ratio = LONG_RATIO_RST;
      report_results_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WEIGHT_MODE) wt_mode = cfg_wdata[0];
        else if (cfg_index == CFG_LONG_RATIO) wt_ratio = cfg_wdata[RATIO_W-1:0];
      end
      // results before requests: a result never comes back in its own cycle
      if (out_valid && out_ready) begin
        if (report_results_q.size() == 0) begin
          errs++;
          $display("%0t: result with no request waiting: upd=%0d cost=%0d wt=%0d",
                   $time, out_data.updated, out_data.link_cost, out_data.route_weight);
        end else begin
          want = report_results_q.pop_front();
          nchk++;
          if (out_data.updated !== want.updated ||
              out_data.link_cost !== want.link_cost ||
              out_data.route_weight !== want.route_weight) begin
            errs++;
            $display("%0t: mismatch: expected upd=%0d cost=%0d wt=%0d, actual upd=%0d cost=%0d wt=%0d",
                     $time, want.updated, want.link_cost, want.route_weight,
                     out_data.updated, out_data.link_cost, out_data.route_weight);
          end
        end
      end
      if (in_valid && in_ready) report_results_q.push_back(estimate_link(in_data));
    end
    fail_count <= errs;
    checked    <= nchk;
    pending    <= report_results_q.size();
  end

endmodule

FILE: test/link_etx_estimator_table_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// link_etx_estimator_table_unit_tb
// Drives report requests and weight settings into the ETX estimator table
// unit, with bursty requests and a stalling result side; the checker does
// the prediction and comparison, this top gives the verdict.
// ---------------------------------------------------------------------------

module link_etx_estimator_table_unit_tb;
  import letx_pkg::*;

  localparam int LIMIT = 200000;   // cycles

  // status codes the package leaves unnamed
  localparam logic [ST_W-1:0] TX_COLLISION  = 3'd1;
  localparam logic [ST_W-1:0] TX_DEFERRED   = 3'd3;
  localparam logic [ST_W-1:0] TX_ERR        = 3'd4;
  localparam logic [ST_W-1:0] TX_FATAL      = 3'd5;
  localparam logic [ST_W-1:0] ST_RSVD6      = 3'd6;
  localparam logic [ST_W-1:0] ST_RSVD7      = 3'd7;
  localparam logic [ST_W-1:0] DAO_ACCEPTED  = 3'd0;
  localparam logic [ST_W-1:0] DAO_ROOT_FULL = 3'd1;
  localparam logic [ST_W-1:0] DAO_RSVD4     = 3'd4;

  localparam int RAND_ITEMS = 400;
  localparam int PHASES     = 6;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int checked;

  link_etx_estimator_table_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  link_etx_estimator_table_unit_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  int cyc;
  initial begin
    cyc = 0;
    while (cyc < LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("tb: failure");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Result side: stall mode re-drawn at random among four. One long hold-off
  // once traffic is flowing (plus rare random ones) lets the result register
  // and the parked sequencer fill, so in_ready drops while requests wait.
  // ------------------------------------------------------------------------
  int rx_mode;
  int rx_tick;
  int hold_left;
  bit held_once;

  initial begin
    out_ready = 1'b0;
    rx_mode   = 0;
    rx_tick   = 0;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if ((!held_once && checked >= 120) || $urandom_range(0, 999) == 0) begin
        held_once = 1'b1;
        hold_left = $urandom_range(40, 80);
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (rx_tick % 3 == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
      if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
    end
  end

  // ------------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------------
  int burst_left;
  int sent;
  int settings_used;

  function automatic in_item_t mk_report(input logic op, input int nb,
                                         input logic [ST_W-1:0] st,
                                         input int cnt, input logic lr);
    in_item_t r;
    r.op            = op;
    r.neighbor      = NB_W'(nb);
    r.status_code   = st;
    r.tx_count      = CNT_W'(cnt);
    r.is_long_range = lr;
    return r;
  endfunction

  // offer one request; bursts of random length with random gaps between
  task automatic send_report(input in_item_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent++;
  endtask

  // stop offering, wait for all results, then let the sequencer settle
  task automatic drain_reports();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  // both registers in back-to-back cycles; spare data bits randomized
  task automatic set_weighting(input logic mode, input logic [RATIO_W-1:0] ratio);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WEIGHT_MODE;
    cfg_wdata <= {3'($urandom), mode};
    @(posedge clk);
    cfg_index <= CFG_LONG_RATIO;
    cfg_wdata <= ratio;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  in_item_t         directed_q [$];
  in_item_t         r;
  int               good;
  logic             ph_mode;
  logic [RATIO_W-1:0] ph_ratio;

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    burst_left = 0;
    sent       = 0;
    settings_used = 1;   // reset defaults
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests under reset weighting (mode 1, ratio 2)
    directed_q.push_back(mk_report(OP_TX,   0, TX_OK,         1,   1'b0)); // first sample
    directed_q.push_back(mk_report(OP_TX,   0, TX_OK,         255, 1'b0)); // moving average
    directed_q.push_back(mk_report(OP_TX,   0, TX_OK,         0,   1'b0)); // zero count
    directed_q.push_back(mk_report(OP_TX,   1, TX_NOACK,      200, 1'b1)); // no-ack penalty
    directed_q.push_back(mk_report(OP_TX,   1, TX_NOACK,      1,   1'b1));
    directed_q.push_back(mk_report(OP_TX,   0, TX_COLLISION,  5,   1'b0));
    directed_q.push_back(mk_report(OP_TX,   0, TX_DEFERRED,   5,   1'b0));
    directed_q.push_back(mk_report(OP_TX,   0, TX_ERR,        5,   1'b1));
    directed_q.push_back(mk_report(OP_TX,   0, TX_FATAL,      5,   1'b0));
    directed_q.push_back(mk_report(OP_TX,   0, ST_RSVD6,      9,   1'b0));
    directed_q.push_back(mk_report(OP_TX,   0, ST_RSVD7,      9,   1'b1));
    directed_q.push_back(mk_report(OP_DAO,  2, DAO_ACCEPTED,  3,   1'b0));
    directed_q.push_back(mk_report(OP_DAO,  2, DAO_ROOT_FULL, 3,   1'b0));
    directed_q.push_back(mk_report(OP_DAO,  2, DAO_UNABLE,    0,   1'b0)); // count unused
    directed_q.push_back(mk_report(OP_DAO,  2, DAO_TIMEOUT,   255, 1'b1));
    directed_q.push_back(mk_report(OP_DAO,  2, DAO_RSVD4,     7,   1'b0));
    directed_q.push_back(mk_report(OP_DAO,  2, ST_RSVD7,      7,   1'b1));
    directed_q.push_back(mk_report(OP_TX,  15, TX_OK,         255, 1'b1)); // top cost, long
    directed_q.push_back(mk_report(OP_TX,  15, TX_OK,         255, 1'b0));
    directed_q.push_back(mk_report(OP_TX,   7, TX_NOACK,      0,   1'b0)); // untouched entry
    directed_q.push_back(mk_report(OP_TX,   8, TX_OK,         170, 1'b1));
    directed_q.push_back(mk_report(OP_TX,   8, TX_OK,         85,  1'b0));
    directed_q.push_back(mk_report(OP_DAO, 15, DAO_UNABLE,    0,   1'b1));
    foreach (directed_q[i]) send_report(directed_q[i]);
    drain_reports();

    // random phases, each under its own weighting; ratio zero and the
    // extremes of both registers included
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin ph_mode = 1'b1; ph_ratio = 4'd15; end
        1: begin ph_mode = 1'b0; ph_ratio = 4'd1;  end
        2: begin ph_mode = 1'b1; ph_ratio = 4'd0;  end
        3: begin ph_mode = 1'b0; ph_ratio = 4'd15; end
        4: begin ph_mode = 1'($urandom); ph_ratio = RATIO_W'($urandom); end
        default: begin ph_mode = WEIGHT_MODE_RST; ph_ratio = LONG_RATIO_RST; end
      endcase
      set_weighting(ph_mode, ph_ratio);
      good = 0;
      while (good < RAND_ITEMS / PHASES) begin
        if ($urandom_range(0, 9) < 7) begin
          // well-formed updating report with random content
          r.neighbor      = NB_W'($urandom);
          r.is_long_range = 1'($urandom);
          case ($urandom_range(0, 3))
            0: begin
              r.op          = OP_TX;
              r.status_code = TX_OK;
              r.tx_count    = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(1, 255))
                                                          : CNT_W'($urandom_range(1, 12));
            end
            1: begin
              r.op          = OP_TX;
              r.status_code = TX_NOACK;
              r.tx_count    = CNT_W'($urandom_range(1, 255));
            end
            2: begin
              r.op          = OP_DAO;
              r.status_code = DAO_UNABLE;
              r.tx_count    = CNT_W'($urandom);
            end
            default: begin
              r.op          = OP_DAO;
              r.status_code = DAO_TIMEOUT;
              r.tx_count    = CNT_W'($urandom);
            end
          endcase
        end else begin
          // noise: any field pattern at all
          r = in_item_t'($urandom);
        end
        send_report(r);
        good++;
      end
      drain_reports();
    end

    $display("summary: %0d report requests over %0d weight settings, %0d results checked",
             sent, settings_used, checked);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/letx_pkg.sv
design/letx_ctrl.sv
design/letx_datapath.sv
design/link_etx_estimator_table_unit.sv
test/link_etx_estimator_table_unit_checker.sv
test/link_etx_estimator_table_unit_tb.sv
